/* rtl/ils_pkg.sv */
// Shared types and constants for the indexed list store.
`default_nettype none

package ils_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;

  // OR-reduction group size of the read tree
  localparam int GROUP = 8;

  localparam logic [DATA_W-1:0] ERR_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_READ   = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // per-request shift control broadcast to every cell; already qualified
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/ils_if.sv */
// Request and response channel interfaces for the indexed list store.
`default_nettype none

interface ils_req_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output position, output value,
                  input ready);
  modport sink   (input valid, input command, input position, input value,
                  output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     error;
  logic [CNT_W-1:0]         count;
  logic                     empty_res;

  modport source (output valid, output read_value, output error, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input read_value, input error, input count,
                  input empty_res, output ready);
endinterface

`default_nettype wire

/* rtl/ils_cell.sv */
// One list cell: holds an entry, shifts from a neighbor or loads new data.
`default_nettype none

module ils_cell #(
  parameter int INDEX = 0,
  parameter int CMPW  = 7
) (
  input  wire logic                       clk_i,
  input  wire ils_pkg::ctrl_t             ctrl_i,
  input  wire logic [CMPW-1:0]            pos_i,
  input  wire logic [ils_pkg::DATA_W-1:0] value_i,
  input  wire logic [ils_pkg::DATA_W-1:0] left_i,
  input  wire logic [ils_pkg::DATA_W-1:0] right_i,
  output logic      [ils_pkg::DATA_W-1:0] data_o,
  output logic      [ils_pkg::DATA_W-1:0] tap_o
);
  import ils_pkg::*;

  localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

  logic [DATA_W-1:0] data_q, data_d;
  logic              hit, above;

  assign hit   = (pos_i == IDX);
  assign above = (pos_i < IDX);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = value_i;
      end
    end else if (ctrl_i.rem) begin
      if (hit || above) begin
        data_d = right_i;
      end
    end else if (ctrl_i.wr && hit) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the addressed cell drives the read tree
  assign tap_o  = hit ? data_q : '0;

endmodule

`default_nettype wire

/* rtl/ils_rdtree.sv */
// Two-level OR tree with registered group results that collects the addressed cell's entry.
`default_nettype none

module ils_rdtree #(
  parameter int N = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire logic [ils_pkg::DATA_W-1:0] taps_i [N],
  output logic      [ils_pkg::DATA_W-1:0] data_o
);
  import ils_pkg::*;

  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [DATA_W-1:0] grp_d [NG];
  logic [DATA_W-1:0] grp_q [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < N) begin
          grp_d[g] = grp_d[g] | taps_i[g * GROUP + k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NG; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule

`default_nettype wire

/* rtl/indexed_list_store_top.sv */
// Top level of the indexed list store: cell chain, read tree and response path.
`default_nettype none

// Usage
//   req_i carries one request per valid/ready handshake: command (insert,
//   read, remove, overwrite, clear), position and value. rsp_o returns one
//   response per request, in order: read_value, error, count, empty_res.
//   Entries live in a chain of CAPACITY cells. Insert and remove move every
//   cell after the position by one place in the same edge that accepts the
//   request, so the list is up to date for the very next request.
//   Pipeline: the response is valid once stage one has registered a grouped
//   OR of the addressed cell and stage two has finished the OR into the
//   output register. Throughput: one request per cycle unless stalled,
//   set by the cell shift on the accepting edge.
//   Stall: when rsp_o.ready is low the output register holds; one more
//   request can sit in stage one, after which req_i.ready drops.
//   Reset: count goes to zero and both pipeline stages empty. Cell contents
//   are not reset; a cell is only read after it has been written.
//   An out-of-range position or an insert into a full list returns error
//   with read_value all ones and leaves the list unchanged.
module indexed_list_store_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);
  import ils_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // request decode
  logic            fire;
  logic            is_ins, is_acc, is_rem, is_wr, is_clr;
  logic            err;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  ctrl_t           ctrl;

  // entry count
  logic [CW-1:0] cnt_q, cnt_d;

  // stage one
  logic          s1_valid_q, s1_err_q, s1_rd_q;
  logic [CW-1:0] s1_cnt_q;
  logic          s1_adv;

  // output register
  logic                     out_valid_q;
  logic                     out_err_q, out_empty_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic signed [DATA_W-1:0] out_val_q;

  logic [DATA_W-1:0] data   [CAPACITY];
  logic [DATA_W-1:0] taps   [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  assign fire    = req_i.valid && req_i.ready;
  assign pos_ext = CMPW'(req_i.position);
  assign cnt_ext = CMPW'(cnt_q);

  always_comb begin
    is_ins = 1'b0;
    is_acc = 1'b0;
    is_rem = 1'b0;
    is_wr  = 1'b0;
    is_clr = 1'b0;
    case (cmd_e'(req_i.command))
      CMD_INSERT: is_ins = 1'b1;
      CMD_READ:   is_acc = 1'b1;
      CMD_REMOVE: begin
        is_acc = 1'b1;
        is_rem = 1'b1;
      end
      CMD_WRITE: begin
        is_acc = 1'b1;
        is_wr  = 1'b1;
      end
      CMD_CLEAR:  is_clr = 1'b1;
      default:    ; // undefined codes: no operation
    endcase
  end

  // insert may append at position == count; access needs position < count
  assign err = (is_ins && ((pos_ext > cnt_ext) || (cnt_q == CAP))) ||
               (is_acc && (pos_ext >= cnt_ext));

  assign ctrl.ins = fire && is_ins && !err;
  assign ctrl.rem = fire && is_rem && !err;
  assign ctrl.wr  = fire && is_wr  && !err;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - 1'b1;
    end else if (fire && is_clr) begin
      cnt_d = '0;
    end
  end

  // cell chain: left neighbor feeds inserts, right neighbor feeds removes
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end

    ils_cell #(
      .INDEX (i),
      .CMPW  (CMPW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .value_i (req_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[i]),
      .tap_o   (taps[i])
    );
  end

  // read tree samples the pre-update contents on the accepting edge
  ils_rdtree #(
    .N (CAPACITY)
  ) u_rdtree (
    .clk_i  (clk_i),
    .load_i (fire),
    .taps_i (taps),
    .data_o (rd_data)
  );

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_err_q <= err;
      s1_rd_q  <= is_acc && !err;
      s1_cnt_q <= cnt_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_err_q   <= s1_err_q;
      out_cnt_q   <= CNT_W'(s1_cnt_q);
      out_empty_q <= (s1_cnt_q == '0);
      if (s1_err_q) begin
        out_val_q <= ERR_VALUE;
      end else if (s1_rd_q) begin
        out_val_q <= rd_data;
      end else begin
        out_val_q <= '0;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_val_q;
  assign rsp_o.error      = out_err_q;
  assign rsp_o.count      = out_cnt_q;
  assign rsp_o.empty_res  = out_empty_q;

endmodule

`default_nettype wire

/* rtl/ils_chk.sv */
// Port-level checks for the indexed list store, bound to the top level.
`default_nettype none

module ils_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       rsp_valid_i,
  input wire logic                       rsp_ready_i,
  input wire logic [ils_pkg::DATA_W-1:0] rsp_value_i,
  input wire logic                       rsp_error_i,
  input wire logic [ils_pkg::CNT_W-1:0]  rsp_count_i,
  input wire logic                       rsp_empty_i
);
  import ils_pkg::*;

  // an error response always carries all ones
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_error_i |-> rsp_value_i == ERR_VALUE)
    else $error("error response without all-ones value");

  // empty flag tracks the reported count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_empty_i == (rsp_count_i == '0))
    else $error("empty flag disagrees with count");

  // a stalled response holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i) &&
      $stable(rsp_count_i) && $stable(rsp_error_i))
    else $error("stalled response changed");

endmodule

bind indexed_list_store_top ils_chk u_ils_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.read_value),
  .rsp_error_i (rsp_o.error),
  .rsp_count_i (rsp_o.count),
  .rsp_empty_i (rsp_o.empty_res)
);

`default_nettype wire
